/* src/itrrs_pkg.sv */
`default_nettype none

package itrrs_pkg;

   // Fixed field widths
   localparam int QueueSlots       = 8;
   localparam int QueueIndexWidth  = 3;
   localparam int EventWidth       = 3;
   localparam int IdleLimitWidth   = 16;
   localparam int CsrDataWidth     = 32;
   localparam int CsrAddrWidth     = 3;

   // Queue slots that exist; slots at or above this count are ignored
   localparam int QueueCount       = 8;
   localparam logic [QueueSlots-1:0] SlotMask =
      (QueueCount >= QueueSlots) ? {QueueSlots{1'b1}}
                                 : QueueSlots'((64'd1 << QueueCount) - 64'd1);

   // Default width of the empty-tick counter
   localparam int CountBitsDefault = 16;

   // Register reset values
   localparam logic [QueueSlots-1:0]     InstalledReset = 8'hFF;
   localparam logic [IdleLimitWidth-1:0] IdleLimitReset = 16'd100;

   // Register indexes (word address bit 2)
   typedef enum logic {
      REG_INSTALLED_MASK = 1'b0,
      REG_IDLE_LIMIT     = 1'b1
   } reg_index_type;

   // Scheduling events
   typedef enum logic [EventWidth-1:0] {
      EV_IDLE      = 3'd0,
      EV_LOAD_REQ  = 3'd1,
      EV_LOAD_DONE = 3'd2,
      EV_LOAD_FAIL = 3'd3,
      EV_EXECUTE   = 3'd4,
      EV_WAIT      = 3'd5,
      EV_RELEASE   = 3'd6
   } ev_type;

   // One scheduling tick
   typedef struct packed {
      logic [QueueSlots-1:0] pending_mask;
      logic                  load_ok;
   } tick_type;

   // Configuration seen by the scheduler
   typedef struct packed {
      logic [QueueSlots-1:0]     installed_mask;
      logic [IdleLimitWidth-1:0] idle_limit;
   } cfg_type;

   // Index of the lowest set bit, zero when none is set
   function automatic logic [QueueIndexWidth-1:0] lowest_bit(input logic [QueueSlots-1:0] m);
      logic [QueueIndexWidth-1:0] idx;
      idx = '0;
      for (int i = QueueSlots - 1; i >= 0; i--) begin
         if (m[i]) idx = QueueIndexWidth'(i);
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

/* src/itrrs_csr.sv */
`default_nettype none

module itrrs_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [itrrs_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [itrrs_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic      [itrrs_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                                    csr_pready,
   output itrrs_pkg::cfg_type                      cfg
);
   import itrrs_pkg::*;

   logic [QueueSlots-1:0]     installed_ff;
   logic [IdleLimitWidth-1:0] idle_limit_ff;
   logic                      write_en;
   reg_index_type             reg_sel;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = reg_index_type'(csr_paddr[2]);

   // Write registers in the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         installed_ff  <= InstalledReset;
         idle_limit_ff <= IdleLimitReset;
      end else if (write_en) begin
         case (reg_sel)
            REG_INSTALLED_MASK: installed_ff  <= csr_pwdata[QueueSlots-1:0];
            REG_IDLE_LIMIT:     idle_limit_ff <= csr_pwdata[IdleLimitWidth-1:0];
            default: ;
         endcase
      end
   end

   // Return the selected register
   always_comb begin
      case (reg_sel)
         REG_INSTALLED_MASK: csr_prdata = CsrDataWidth'(installed_ff);
         REG_IDLE_LIMIT:     csr_prdata = CsrDataWidth'(idle_limit_ff);
         default:            csr_prdata = '0;
      endcase
   end

   assign cfg.installed_mask = installed_ff;
   assign cfg.idle_limit     = idle_limit_ff;

endmodule

`default_nettype wire

/* src/itrrs_input_stage.sv */
`default_nettype none

module itrrs_input_stage (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [itrrs_pkg::QueueSlots-1:0] req_pending_mask,
   input  wire logic                             req_load_ok,
   output logic                                  tick_valid,
   input  wire logic                             tick_ready,
   output itrrs_pkg::tick_type                   tick
);
   import itrrs_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   tick_type tick_ff;

   // Take a new word when empty or when the held one moves on
   assign req_ready = !valid_ff || tick_ready;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload until it is consumed
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         tick_ff.pending_mask <= req_pending_mask;
         tick_ff.load_ok      <= req_load_ok;
      end
   end

   assign tick_valid = valid_ff;
   assign tick       = tick_ff;

endmodule

`default_nettype wire

/* src/itrrs_sched_core.sv */
`default_nettype none

module itrrs_sched_core #(
   parameter int COUNT_BITS = itrrs_pkg::CountBitsDefault
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire itrrs_pkg::cfg_type                    cfg,
   input  wire logic                                  tick_valid,
   output logic                                       tick_ready,
   input  wire itrrs_pkg::tick_type                   tick,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic      [itrrs_pkg::EventWidth-1:0]      rsp_event_res,
   output logic      [itrrs_pkg::QueueIndexWidth-1:0] rsp_queue_index,
   output logic      [itrrs_pkg::QueueSlots-1:0]      rsp_dropped_mask
);
   import itrrs_pkg::*;

   localparam int LimW = (COUNT_BITS > IdleLimitWidth) ? COUNT_BITS : IdleLimitWidth;

   // Scheduler state
   logic [QueueSlots-1:0]      dropped_ff, dropped_in;
   logic [QueueSlots-1:0]      snap_ff, snap_in;
   logic [QueueIndexWidth-1:0] current_ff, current_in;
   logic                       serving_ff, serving_in;
   logic                       loading_ff, loading_in;
   logic [COUNT_BITS-1:0]      count_ff, count_in;

   // Result register
   logic                       rsp_valid_ff;
   ev_type                     event_ff;
   logic [QueueIndexWidth-1:0] queue_ff;
   logic [QueueSlots-1:0]      rsp_dropped_ff;

   logic                       advance;
   logic [QueueSlots-1:0]      installed;
   logic                       single;
   logic [QueueSlots-1:0]      usable;
   logic [QueueSlots-1:0]      qbit;
   logic [QueueSlots-1:0]      snap_base;
   logic [QueueSlots-1:0]      avail;
   logic [COUNT_BITS-1:0]      count_inc;
   logic [LimW-1:0]            lim_ext;
   logic [LimW-1:0]            cmax_ext;
   logic [LimW-1:0]            lim;
   logic                       lim_zero;
   ev_type                     ev_c;
   logic [QueueIndexWidth-1:0] q_c;

   // Move a word when the result register can take it
   assign tick_ready = !rsp_valid_ff || rsp_ready;
   assign advance    = tick_valid && tick_ready;

   // Decode configuration and current state
   assign installed = cfg.installed_mask & SlotMask;
   assign single    = (installed != '0) && ((installed & (installed - QueueSlots'(1))) == '0);
   assign usable    = installed & ~dropped_ff;
   assign qbit      = QueueSlots'(1) << current_ff;
   assign snap_base = ((snap_ff & usable) == '0) ? (tick.pending_mask & usable) : snap_ff;
   assign avail     = snap_base & usable;

   // Effective limit is the smaller of the register and the counter ceiling
   assign count_inc = (count_ff == {COUNT_BITS{1'b1}}) ? count_ff : count_ff + COUNT_BITS'(1);
   assign lim_ext   = LimW'(cfg.idle_limit);
   assign cmax_ext  = LimW'({COUNT_BITS{1'b1}});
   assign lim       = (lim_ext > cmax_ext) ? cmax_ext : lim_ext;
   assign lim_zero  = (cfg.idle_limit == '0);

   // Decide the event and next state for one tick
   always_comb begin
      dropped_in = dropped_ff;
      snap_in    = snap_ff;
      current_in = current_ff;
      serving_in = serving_ff;
      loading_in = loading_ff;
      count_in   = count_ff;
      ev_c       = EV_IDLE;
      q_c        = '0;
      if (loading_ff) begin
         loading_in = 1'b0;
         q_c        = current_ff;
         if (tick.load_ok) begin
            serving_in = 1'b1;
            count_in   = '0;
            ev_c       = EV_LOAD_DONE;
         end else begin
            dropped_in = dropped_ff | qbit;
            snap_in    = snap_ff & ~qbit;
            ev_c       = EV_LOAD_FAIL;
         end
      end else if (serving_ff) begin
         q_c = current_ff;
         if (!single && lim_zero) begin
            ev_c = EV_RELEASE;
         end else if ((tick.pending_mask & qbit) != '0) begin
            count_in = '0;
            ev_c     = EV_EXECUTE;
         end else if (single) begin
            ev_c = EV_WAIT;
         end else begin
            count_in = count_inc;
            ev_c     = (LimW'(count_inc) >= lim) ? EV_RELEASE : EV_WAIT;
         end
         if (ev_c == EV_RELEASE) begin
            serving_in = 1'b0;
            count_in   = '0;
            snap_in    = snap_ff & ~qbit;
         end
      end else if (single) begin
         if (usable != '0) begin
            current_in = lowest_bit(usable);
            loading_in = 1'b1;
            q_c        = lowest_bit(usable);
            ev_c       = EV_LOAD_REQ;
         end
      end else begin
         snap_in = snap_base;
         if (avail != '0) begin
            current_in = lowest_bit(avail);
            loading_in = 1'b1;
            q_c        = lowest_bit(avail);
            ev_c       = EV_LOAD_REQ;
         end
      end
   end

   // Advance state on each consumed word
   always_ff @(posedge clock) begin
      if (reset) begin
         dropped_ff <= '0;
         snap_ff    <= '0;
         current_ff <= '0;
         serving_ff <= 1'b0;
         loading_ff <= 1'b0;
         count_ff   <= '0;
      end else if (advance) begin
         dropped_ff <= dropped_in;
         snap_ff    <= snap_in;
         current_ff <= current_in;
         serving_ff <= serving_in;
         loading_ff <= loading_in;
         count_ff   <= count_in;
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (tick_ready) begin
         rsp_valid_ff <= tick_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         event_ff       <= ev_c;
         queue_ff       <= q_c;
         rsp_dropped_ff <= dropped_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_res    = event_ff;
   assign rsp_queue_index  = queue_ff;
   assign rsp_dropped_mask = rsp_dropped_ff;

`ifndef SYNTHESIS
   a_load_serve_excl: assert property (@(posedge clock) disable iff (reset)
      !(loading_ff && serving_ff))
      else $error("loading and serving both set");

   a_req_sets_loading: assert property (@(posedge clock) disable iff (reset)
      (advance && ev_c == EV_LOAD_REQ) |=> loading_ff)
      else $error("load request did not enter loading");

   a_dropped_sticky: assert property (@(posedge clock) disable iff (reset)
      advance |=> ((dropped_ff & $past(dropped_ff)) == $past(dropped_ff)))
      else $error("dropped queue came back");

   a_fail_marks_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && event_ff == EV_LOAD_FAIL) |-> rsp_dropped_ff[queue_ff])
      else $error("failed load not reported as dropped");
`endif

endmodule

`default_nettype wire

/* src/idle_timeout_round_robin_switch.sv */
// A tick is held in the input register, and its result in the result register, which
// keeps it until the result side takes it.
// Throughput: one tick per cycle while the result side does not stall; the decision is one pass of priority pick,
// mask update and counter compare between the input and result registers.
// Reset (synchronous, active high) clears the scheduler state and both valid
// flags, and sets installed_mask to 255 and idle_limit to 100.
`default_nettype none

module idle_timeout_round_robin_switch #(
   parameter int COUNT_BITS = itrrs_pkg::CountBitsDefault
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [itrrs_pkg::QueueSlots-1:0]      req_pending_mask,
   input  wire logic                                  req_load_ok,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic      [itrrs_pkg::EventWidth-1:0]      rsp_event_res,
   output logic      [itrrs_pkg::QueueIndexWidth-1:0] rsp_queue_index,
   output logic      [itrrs_pkg::QueueSlots-1:0]      rsp_dropped_mask,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [itrrs_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  wire logic [itrrs_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic      [itrrs_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                       csr_pready
);
   import itrrs_pkg::*;

   cfg_type  cfg;
   tick_type tick;
   logic     tick_valid;
   logic     tick_ready;

   itrrs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   itrrs_input_stage u_input (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pending_mask (req_pending_mask),
      .req_load_ok      (req_load_ok),
      .tick_valid       (tick_valid),
      .tick_ready       (tick_ready),
      .tick             (tick)
   );

   itrrs_sched_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .tick_valid       (tick_valid),
      .tick_ready       (tick_ready),
      .tick             (tick),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_res    (rsp_event_res),
      .rsp_queue_index  (rsp_queue_index),
      .rsp_dropped_mask (rsp_dropped_mask)
   );

endmodule

`default_nettype wire

/* verif/idle_timeout_round_robin_switch_tb.sv */
`timescale 1ns / 1ps

// Tracks the scheduler state and queues the expected event word per tick
class grant_tracker;
   typedef struct {
      itrrs_pkg::ev_type         ev;
      logic [2:0]                queue;
      logic [7:0]                dropped;
   } sched_word_type;

   // Register copies
   logic [7:0]  installed;
   logic [15:0] limit;

   // Scheduler state
   logic [7:0]  dropped;
   logic [7:0]  snapshot;
   logic [2:0]  cur_queue;
   bit          serving;
   bit          loading;
   logic [itrrs_pkg::CountBitsDefault-1:0] empty_ticks;

   sched_word_type expected_events[$];

   function new();
      installed   = itrrs_pkg::InstalledReset;
      limit       = itrrs_pkg::IdleLimitReset;
      dropped     = '0;
      snapshot    = '0;
      cur_queue   = '0;
      serving     = 0;
      loading     = 0;
      empty_ticks = '0;
   endfunction

   function void set_reg(itrrs_pkg::reg_index_type idx, logic [31:0] value);
      if (idx == itrrs_pkg::REG_INSTALLED_MASK) installed = value[7:0];
      else limit = value[15:0];
   endfunction

   // Pick the lowest set slot, scanning upward
   function logic [2:0] first_slot(logic [7:0] m);
      for (int i = 0; i < 8; i++)
         if (m[i]) return 3'(i);
      return 3'd0;
   endfunction

   // Advance the state by one accepted tick and queue its event word
   function void note_tick(logic [7:0] pending, logic ok);
      logic [7:0]        inst;
      logic [7:0]        usable;
      logic [7:0]        qbit;
      bit                one_queue;
      longint unsigned   cnt_max;
      longint unsigned   lim;
      sched_word_type    w;

      inst      = installed & itrrs_pkg::SlotMask;
      one_queue = ($countones(inst) == 1);
      usable    = inst & ~dropped;
      qbit      = 8'd1 << cur_queue;
      cnt_max   = (64'd1 << itrrs_pkg::CountBitsDefault) - 64'd1;
      w.ev      = itrrs_pkg::EV_IDLE;
      w.queue   = '0;

      if (loading) begin
         // Resolve the outstanding load
         loading = 0;
         w.queue = cur_queue;
         if (ok) begin
            serving     = 1;
            empty_ticks = '0;
            w.ev        = itrrs_pkg::EV_LOAD_DONE;
         end else begin
            dropped  = dropped | qbit;
            snapshot = snapshot & ~qbit;
            w.ev     = itrrs_pkg::EV_LOAD_FAIL;
         end
      end else if (serving) begin
         // Execute, wait or release the granted queue
         lim = limit;
         if (lim > cnt_max) lim = cnt_max;
         w.queue = cur_queue;
         if (!one_queue && lim == 0) begin
            w.ev = itrrs_pkg::EV_RELEASE;
         end else if ((pending & qbit) != 0) begin
            empty_ticks = '0;
            w.ev        = itrrs_pkg::EV_EXECUTE;
         end else if (one_queue) begin
            w.ev = itrrs_pkg::EV_WAIT;
         end else begin
            if (empty_ticks < cnt_max) empty_ticks = empty_ticks + 1'b1;
            w.ev = (empty_ticks >= lim) ? itrrs_pkg::EV_RELEASE : itrrs_pkg::EV_WAIT;
         end
         if (w.ev == itrrs_pkg::EV_RELEASE) begin
            serving     = 0;
            empty_ticks = '0;
            snapshot    = snapshot & ~qbit;
         end
      end else if (one_queue) begin
         // Load the only queue whether or not it has work
         if (usable != 0) begin
            cur_queue = first_slot(usable);
            loading   = 1;
            w.queue   = cur_queue;
            w.ev      = itrrs_pkg::EV_LOAD_REQ;
         end
      end else begin
         // Refresh the snapshot once it runs dry, then request the lowest entry
         if ((snapshot & usable) == 0) snapshot = pending & usable;
         if ((snapshot & usable) != 0) begin
            cur_queue = first_slot(snapshot & usable);
            loading   = 1;
            w.queue   = cur_queue;
            w.ev      = itrrs_pkg::EV_LOAD_REQ;
         end
      end

      w.dropped = dropped;
      expected_events.insert(expected_events.size(), w);
   endfunction

   // Compare one result word with the oldest expectation; empty string on match
   function string check_event(logic [2:0] ev, logic [2:0] queue, logic [7:0] dm);
      sched_word_type w;
      string          msg;
      if (expected_events.size() == 0) return "result word with nothing expected";
      w   = expected_events[0];
      expected_events.delete(0);
      msg = "";
      if (ev !== w.ev)
         msg = {msg, $sformatf(" event %0d exp %0d", ev, w.ev)};
      if (queue !== w.queue)
         msg = {msg, $sformatf(" queue %0d exp %0d", queue, w.queue)};
      if (dm !== w.dropped)
         msg = {msg, $sformatf(" dropped %h exp %h", dm, w.dropped)};
      return msg;
   endfunction
endclass

module idle_timeout_round_robin_switch_tb;
   import itrrs_pkg::*;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_pending_mask;
   logic        req_load_ok;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_event_res;
   logic [2:0]  rsp_queue_index;
   logic [7:0]  rsp_dropped_mask;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   grant_tracker sb = new();
   int           error_count = 0;
   bit           no_gaps = 0;

   idle_timeout_round_robin_switch u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pending_mask (req_pending_mask),
      .req_load_ok      (req_load_ok),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_res    (rsp_event_res),
      .rsp_queue_index  (rsp_queue_index),
      .rsp_dropped_mask (rsp_dropped_mask),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #5 clock = ~clock;

   task automatic report(string msg);
      $display("MISMATCH at %0t:%s", $time, msg);
      error_count++;
   endtask

   // Check each accepted result word and stall the result side at random
   always @(posedge clock) begin
      string msg;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            msg = sb.check_event(rsp_event_res, rsp_queue_index, rsp_dropped_mask);
            if (msg != "") report(msg);
         end
         rsp_ready <= no_gaps || ($urandom_range(99) >= 7);
      end
   end

   // Offer one tick word, with an occasional gap first, and hold until taken
   task automatic send_tick(logic [7:0] pending, logic ok);
      if (!no_gaps && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < 30) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_pending_mask <= pending;
      req_load_ok      <= ok;
      do @(posedge clock); while (!req_ready);
      sb.note_tick(pending, ok);
   endtask

   // Drop valid and wait until every expected word has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_events.size() != 0) @(posedge clock);
   endtask

   // Setup then access cycle; the idle cycle after keeps writes apart
   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_reg(idx, value);
      @(posedge clock);
   endtask

   // Random ticks: mostly good loads, with rare failures while enough queues live
   task automatic run_phase(int n, int busy_pct);
      logic [7:0] pm;
      logic       ok;
      repeat (n) begin
         if ($urandom_range(9) == 0) begin
            pm = 8'($urandom);
         end else begin
            for (int b = 0; b < 8; b++) pm[b] = ($urandom_range(99) < busy_pct);
         end
         if (sb.loading)
            ok = !($urandom_range(47) == 0 && $countones(~sb.dropped) > 3);
         else
            ok = 1'($urandom_range(1));
         send_tick(pm, ok);
      end
   endtask

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      logic [7:0] mask;
      int         slot;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_pending_mask = '0;
      req_load_ok      = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: idle, failed load drops a queue, grant with ignored load_ok
      send_tick(8'h00, 1'b0);
      send_tick(8'h00, 1'b1);
      send_tick(8'h81, 1'b1);
      send_tick(8'h81, 1'b0);
      send_tick(8'hFF, 1'b0);
      send_tick(8'h00, 1'b1);
      send_tick(8'h80, 1'b0);
      send_tick(8'h7F, 1'b1);
      send_tick(8'h00, 1'b0);

      // Zero limit releases at once; stale snapshot entries still get loaded
      drain();
      csr_write(REG_IDLE_LIMIT, 32'd0);
      send_tick(8'h80, 1'b1);
      send_tick(8'hFF, 1'b1);
      send_tick(8'h00, 1'b1);
      send_tick(8'hFF, 1'b1);
      send_tick(8'h00, 1'b1);
      send_tick(8'h00, 1'b1);

      // Registers change under a grant; then no usable queue at all
      drain();
      csr_write(REG_IDLE_LIMIT, 32'd2);
      csr_write(REG_INSTALLED_MASK, 32'h00);
      send_tick(8'hFF, 1'b1);
      send_tick(8'h00, 1'b1);
      send_tick(8'h00, 1'b1);
      send_tick(8'hFF, 1'b1);

      // Single queue whose load fails stays idle
      drain();
      csr_write(REG_INSTALLED_MASK, 32'h08);
      csr_write(REG_IDLE_LIMIT, 32'hFFFF);
      send_tick(8'h00, 1'b1);
      send_tick(8'h00, 1'b0);
      send_tick(8'hFF, 1'b1);

      // Single queue loads without work and never switches
      drain();
      csr_write(REG_INSTALLED_MASK, 32'h10);
      send_tick(8'h00, 1'b1);
      send_tick(8'h00, 1'b1);
      send_tick(8'h00, 1'b0);
      send_tick(8'h10, 1'b1);

      // Random phases over a spread of settings
      drain();
      csr_write(REG_INSTALLED_MASK, 32'hFF);
      csr_write(REG_IDLE_LIMIT, 32'd1);
      run_phase(120, 50);

      drain();
      csr_write(REG_IDLE_LIMIT, 32'd0);
      run_phase(100, 60);

      // Long stretch without gaps on either side
      drain();
      csr_write(REG_IDLE_LIMIT, 32'd3);
      no_gaps = 1;
      run_phase(120, 30);
      no_gaps = 0;

      drain();
      do mask = 8'($urandom); while ($countones(mask) < 2);
      csr_write(REG_INSTALLED_MASK, {24'd0, mask});
      csr_write(REG_IDLE_LIMIT, 32'd2);
      run_phase(120, 40);

      drain();
      do slot = $urandom_range(7); while (sb.dropped[slot] && sb.dropped != 8'hFF);
      csr_write(REG_INSTALLED_MASK, 32'd1 << slot);
      run_phase(60, 50);

      drain();
      csr_write(REG_INSTALLED_MASK, 32'hFF);
      csr_write(REG_IDLE_LIMIT, 32'hFFFF);
      run_phase(80, 70);

      drain();
      csr_write(REG_IDLE_LIMIT, 32'd12);
      run_phase(150, 10);

      // Let any stray result word show up before the verdict
      drain();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

/* filelist.f */
src/itrrs_pkg.sv
src/itrrs_csr.sv
src/itrrs_input_stage.sv
src/itrrs_sched_core.sv
src/idle_timeout_round_robin_switch.sv
verif/idle_timeout_round_robin_switch_tb.sv
